[design/psag_pkg.sv]
// Package for the pair-sum address generator.
// Holds the item structs, field widths, list depth and register indexes.
// No dependencies.
`default_nettype none

package psag_pkg;

    localparam int MAX_LIST = 32;
    localparam int RANK_W   = 24;
    localparam int ADDR_W   = 32;
    localparam int LIMIT_W  = 13;
    localparam int ENTRY_W  = 25;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W    = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
    localparam int CNT_W    = $clog2(MAX_LIST + 1);

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_ENTRIES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLAIN_BASE     = 2'd3;

    typedef struct packed {
        logic [RANK_W-1:0] item_rank;
        logic              list_end;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_pair;
        logic              last;
    } out_item_t;

endpackage

`default_nettype wire

[design/psag_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used as the plain-address buffer. No dependencies.
`default_nettype none

module psag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]               wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/pair_sum_address_generator.sv]
// Pair-sum address generator, top level.
// Depends on psag_pkg and psag_ram.
//
// Usage:
//  s_ channel takes one rank per item; list_end marks the final rank of a list.
//  m_ channel gives addresses; last marks the final address of a list.
//  cfg_we/cfg_index/cfg_wdata write pair_limit, table_entries, single_entries
//  and plain_base; write them only while the block is idle.
// Timing:
//  The first rank of a pair is only taken and held.
//  A second rank, or a lone rank with list_end, passes through capture,
//  evaluation with the multiplier and two result slots.
//  If the buffer holds addresses, a list end then reads it: a RAM read step, then
//  one buffered address per cycle while m_ is free. The buffer RAM port sets that flush rate.
//  Results enter the output register in the slot and flush steps before they appear on m_.
// Reset: resets the state, configuration, held-rank flag, buffer fill count and output valid.
//  The buffer RAM itself is not cleared; the fill count guards it.
// Stall: a held output keeps its value; the block waits in its current step and
//  s_ready stays low until the item's results have all entered the output register.
`default_nettype none

module pair_sum_address_generator
    import psag_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_item,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SLOT0 = 3'd2;
    localparam logic [2:0] S_SLOT1 = 3'd3;
    localparam logic [2:0] S_FREAD = 3'd4;
    localparam logic [2:0] S_FOUT  = 3'd5;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_OUT  = 2'd1;
    localparam logic [1:0] K_BUF  = 2'd2;

    localparam int PROD_W = 2 * LIMIT_W + 1;

    logic [2:0]          state_reg;
    logic [LIMIT_W-1:0]  pair_limit_reg;
    logic [ENTRY_W-1:0]  table_entries_reg;
    logic [ENTRY_W-1:0]  single_entries_reg;
    logic [ADDR_W-1:0]   plain_base_reg;

    logic [RANK_W-1:0]   held_rank_reg;
    logic                held_valid_reg;
    logic [RANK_W-1:0]   a_reg;
    logic [RANK_W-1:0]   b_reg;
    logic                pair_reg;
    logic                end_reg;

    logic [PROD_W-1:0]   prod_reg;
    logic [1:0]          kind0_reg;
    logic [1:0]          kind1_reg;
    logic [ADDR_W-1:0]   addr0_reg;
    logic [ADDR_W-1:0]   addr1_reg;
    logic                pair_ok_reg;
    logic                flush_any_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    logic                s_accept;
    logic                out_free;
    logic                push;
    out_item_t           push_item;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [RANK_W-1:0]   wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [RANK_W-1:0]   rd_data;
    logic                buf_room;
    logic                flush_last;

    logic                both_ok;
    logic [LIMIT_W:0]    mul_rhs;
    logic [1:0]          kind0_eval;
    logic [1:0]          kind1_eval;
    logic [ADDR_W-1:0]   pair_addr;

    function automatic logic [1:0] lone_kind(
        input logic [RANK_W-1:0]  r,
        input logic [ENTRY_W-1:0] single_n,
        input logic [ENTRY_W-1:0] table_n
    );
        logic [1:0] k;
        if ({1'b0, r} < single_n) begin
            k = K_OUT;
        end else if ({1'b0, r} < table_n) begin
            k = K_BUF;
        end else begin
            k = K_OUT;
        end
        return k;
    endfunction

    function automatic logic [ADDR_W-1:0] lone_addr(
        input logic [RANK_W-1:0]  r,
        input logic [ENTRY_W-1:0] single_n,
        input logic [ENTRY_W-1:0] table_n
    );
        logic [ADDR_W-1:0] v;
        if ({1'b0, r} < single_n) begin
            v = ADDR_W'(r);
        end else begin
            v = ADDR_W'(r) - ADDR_W'(table_n);
        end
        return v;
    endfunction

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign buf_room = (count_reg < CNT_W'(MAX_LIST));
    assign flush_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // evaluation of a captured pair or lone rank
    assign both_ok = pair_reg && (a_reg <= RANK_W'(pair_limit_reg))
                     && (b_reg <= RANK_W'(pair_limit_reg));
    assign mul_rhs = {pair_limit_reg, 1'b0} - (LIMIT_W+1)'(1) - (LIMIT_W+1)'(a_reg);

    always_comb begin
        if (both_ok) begin
            kind0_eval = K_OUT;
        end else if (pair_reg) begin
            kind0_eval = lone_kind(a_reg, single_entries_reg, table_entries_reg);
        end else begin
            kind0_eval = K_NONE;
        end
        if (both_ok) begin
            kind1_eval = K_NONE;
        end else begin
            kind1_eval = lone_kind(b_reg, single_entries_reg, table_entries_reg);
        end
    end

    assign pair_addr = ADDR_W'(single_entries_reg) + ADDR_W'(prod_reg[PROD_W-1:1])
                       + ADDR_W'(b_reg) - ADDR_W'(a_reg) - ADDR_W'(1);

    always_comb begin
        push      = 1'b0;
        push_item = '0;
        wr_en     = 1'b0;
        wr_data   = a_reg;
        rd_en     = 1'b0;
        rd_addr   = idx_reg;
        case (state_reg)
            S_SLOT0: begin
                if (kind0_reg == K_OUT && out_free) begin
                    push              = 1'b1;
                    push_item.address = pair_ok_reg ? pair_addr : addr0_reg;
                    push_item.is_pair = pair_ok_reg;
                    push_item.last    = end_reg && (kind1_reg != K_OUT) && !flush_any_reg;
                end
                if (kind0_reg == K_BUF && buf_room) begin
                    wr_en = 1'b1;
                end
            end
            S_SLOT1: begin
                wr_data = b_reg;
                if (kind1_reg == K_OUT && out_free) begin
                    push              = 1'b1;
                    push_item.address = addr1_reg;
                    push_item.is_pair = 1'b0;
                    push_item.last    = end_reg && !flush_any_reg;
                end
                if (kind1_reg == K_BUF && buf_room) begin
                    wr_en = 1'b1;
                end
            end
            S_FREAD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_FOUT: begin
                if (out_free) begin
                    push              = 1'b1;
                    push_item.address = ADDR_W'(rd_data) + plain_base_reg;
                    push_item.is_pair = 1'b0;
                    push_item.last    = flush_last;
                    rd_en             = !flush_last;
                    rd_addr           = idx_reg + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign wr_addr = count_reg[IDX_W-1:0];

    psag_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_LIST)
    ) u_plain_buf (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_limit_reg     <= '0;
            table_entries_reg  <= ENTRY_W'(1);
            single_entries_reg <= '0;
            plain_base_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PAIR_LIMIT:     pair_limit_reg     <= cfg_wdata[LIMIT_W-1:0];
                REG_TABLE_ENTRIES:  table_entries_reg  <= cfg_wdata[ENTRY_W-1:0];
                REG_SINGLE_ENTRIES: single_entries_reg <= cfg_wdata[ENTRY_W-1:0];
                REG_PLAIN_BASE:     plain_base_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_reg   <= held_rank_reg;
            b_reg   <= s_item.item_rank;
            pair_reg <= held_valid_reg;
            end_reg <= s_item.list_end;
        end
        if (state_reg == S_EVAL) begin
            prod_reg      <= PROD_W'(a_reg[LIMIT_W-1:0] * mul_rhs);
            kind0_reg     <= kind0_eval;
            kind1_reg     <= kind1_eval;
            addr0_reg     <= lone_addr(a_reg, single_entries_reg, table_entries_reg);
            addr1_reg     <= lone_addr(b_reg, single_entries_reg, table_entries_reg);
            pair_ok_reg   <= both_ok;
            flush_any_reg <= (count_reg != '0) || (kind0_eval == K_BUF)
                             || (kind1_eval == K_BUF);
        end
        if (push) begin
            m_item_reg <= push_item;
        end
        if (s_accept && !held_valid_reg && !s_item.list_end) begin
            held_rank_reg <= s_item.item_rank;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (held_valid_reg || s_item.list_end) begin
                            held_valid_reg <= 1'b0;
                            state_reg      <= S_EVAL;
                        end else begin
                            held_valid_reg <= 1'b1;
                        end
                    end
                end
                S_EVAL: begin
                    state_reg <= S_SLOT0;
                end
                S_SLOT0: begin
                    if (!(kind0_reg == K_OUT && !out_free)) begin
                        state_reg <= S_SLOT1;
                    end
                end
                S_SLOT1: begin
                    if (!(kind1_reg == K_OUT && !out_free)) begin
                        state_reg <= (end_reg && flush_any_reg) ? S_FREAD : S_IDLE;
                    end
                end
                S_FREAD: begin
                    idx_reg   <= '0;
                    state_reg <= S_FOUT;
                end
                S_FOUT: begin
                    if (out_free) begin
                        if (flush_last) begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/psag_checker.sv]
// Port-level checks for the pair-sum address generator.
// Depends on psag_pkg; bound to pair_sum_address_generator below.
`default_nettype none

module psag_checker
    import psag_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_item,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a list end always starts result work, so input is closed next cycle
    a_end_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.list_end |=> !s_ready)
        else $error("input open right after list end item");

    // results pass through the evaluation step, so taking an item never raises m_valid at once
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after an item");

endmodule

bind pair_sum_address_generator psag_checker u_psag_checker (.*);

`default_nettype wire
